### design/assert_macros.svh
// Assertion macros for the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_RST(label, clk, prop)
`endif
`endif

### design/strm_pkg.sv
// Shared types and constants of the traffic rate meter
package strm_pkg;
  localparam int unsigned DivW = 64;
  localparam int unsigned DtW = 48;
  localparam int unsigned CntW = 7;
  localparam logic [9:0] MsPerSec = 10'd1000;
  localparam logic [15:0] WindowReset = 16'd1000;

  typedef enum logic [2:0] {
    OP_INGRESS = 3'd0,
    OP_EGRESS  = 3'd1,
    OP_VIDEO   = 3'd2,
    OP_AUDIO   = 3'd3,
    OP_DROP    = 3'd4,
    OP_QUERY   = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [23:0] byte_count;
    logic [47:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [63:0] ingress_total;
    logic [63:0] egress_total;
    logic [63:0] ingress_rate;
    logic [63:0] egress_rate;
    logic [31:0] video_rate;
    logic [31:0] audio_rate;
    logic [63:0] drop_total;
  } out_word_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DtW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;
endpackage

### design/strm_if.sv
// Valid/ready channel interfaces for input and result words
interface strm_in_if (input logic clk);
  import strm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface strm_out_if (input logic clk);
  import strm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/strm_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle
module strm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  strm_pkg::div_req_t req,
  output strm_pkg::div_rsp_t rsp
);
  import strm_pkg::*;

  logic [DivW-1:0] quo_r, quo_nxt;
  logic [DtW:0]    rem_r, rem_nxt;
  logic [DtW-1:0]  dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DtW:0]    trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DtW-1:0], quo_r[DivW-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DivW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

### design/stream_traffic_rate_meter.sv
// Top level: event counters, window sequencer and shared divider
//   channel | dir | handshake          | word
//   in_     | in  | valid/ready        | operation, byte_count, now_ms
//   out_    | out | valid/ready        | totals, rates, drops
//   cfg_    | in  | cfg_we, cfg_wdata  | window_ms
// Drop, clear and unused words free the input at once; a counting event
// holds it through a window check, a window refresh also through two
// divisions and a query through both window checks with up to four
// divisions plus the output handshake, on the one shared 64-step divider.
// Reset is synchronous; counters, marks, rates and sequencer clear, window_ms returns to 1000.
// Input is not ready while an item is in work or a result waits.
`include "assert_macros.svh"
module stream_traffic_rate_meter (
  input  logic        clk,
  input  logic        rst_n,
  strm_in_if.sink     in_ch,
  strm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import strm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_FRAME, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1, S_DONE, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] window_r;
  logic [63:0] ing_sum_r, egr_sum_r, ing_mark_r, egr_mark_r;
  logic [47:0] bstart_r, fstart_r;
  logic [63:0] ing_spd_r, egr_spd_r;
  logic [63:0] vid_r, aud_r, vid_mark_r, aud_mark_r;
  logic [31:0] vid_spd_r, aud_spd_r;
  logic [63:0] drops_r;
  logic [63:0] q0_r, q1_r;
  logic [47:0] now_r, dt_r;
  logic        query_r, frame_r, ph_r;
  out_word_t   res_r;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [47:0] start_sel;
  logic [63:0] d0, d1;
  logic [63:0] p0, p1;

  strm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign start_sel = frame_r ? fstart_r : bstart_r;
  assign d0 = frame_r ? (vid_r - vid_mark_r) : (ing_sum_r - ing_mark_r);
  assign d1 = frame_r ? (aud_r - aud_mark_r) : (egr_sum_r - egr_mark_r);
  assign p0 = d0 * 64'(MsPerSec);
  assign p1 = d1 * 64'(MsPerSec);

  always_comb begin
    dreq.start    = (state_r == S_DIV0) || (state_r == S_DIV1);
    dreq.dividend = (state_r == S_DIV1) ? q1_r : q0_r;
    dreq.divisor  = dt_r;
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      window_r <= WindowReset;
      ing_sum_r <= '0; egr_sum_r <= '0; ing_mark_r <= '0; egr_mark_r <= '0;
      bstart_r <= '0; fstart_r <= '0; ing_spd_r <= '0; egr_spd_r <= '0;
      vid_r <= '0; aud_r <= '0; vid_mark_r <= '0; aud_mark_r <= '0;
      vid_spd_r <= '0; aud_spd_r <= '0; drops_r <= '0;
      query_r <= 1'b0; frame_r <= 1'b0; ph_r <= 1'b0;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            now_r   <= in_ch.data.now_ms;
            query_r <= 1'b0;
            ph_r    <= 1'b0;
            case (op_t'(in_ch.data.operation))
              OP_INGRESS: if (in_ch.data.byte_count != '0) begin
                ing_sum_r <= ing_sum_r + 64'(in_ch.data.byte_count);
                frame_r <= 1'b0; state_r <= S_BYTE;
              end
              OP_EGRESS: if (in_ch.data.byte_count != '0) begin
                egr_sum_r <= egr_sum_r + 64'(in_ch.data.byte_count);
                frame_r <= 1'b0; state_r <= S_BYTE;
              end
              OP_VIDEO: begin
                vid_r <= vid_r + 64'd1; frame_r <= 1'b1; state_r <= S_FRAME;
              end
              OP_AUDIO: begin
                aud_r <= aud_r + 64'd1; frame_r <= 1'b1; state_r <= S_FRAME;
              end
              OP_DROP: drops_r <= drops_r + 64'd1;
              OP_QUERY: begin
                query_r <= 1'b1; frame_r <= 1'b0; state_r <= S_BYTE;
                res_r.ingress_rate <= ing_spd_r;
                res_r.egress_rate  <= egr_spd_r;
                res_r.video_rate   <= vid_spd_r;
                res_r.audio_rate   <= aud_spd_r;
              end
              OP_CLEAR: begin
                ing_sum_r <= '0; egr_sum_r <= '0; ing_mark_r <= '0;
                egr_mark_r <= '0; bstart_r <= '0; fstart_r <= '0;
                ing_spd_r <= '0; egr_spd_r <= '0; vid_r <= '0; aud_r <= '0;
                vid_mark_r <= '0; aud_mark_r <= '0; vid_spd_r <= '0;
                aud_spd_r <= '0; drops_r <= '0;
              end
              default: ;
            endcase
          end
        end
        S_BYTE, S_FRAME: begin
          // window check for the group selected by frame_r
          dt_r <= now_r - start_sel;
          q0_r <= p0;
          q1_r <= p1;
          if (start_sel == '0) begin
            if (!query_r) begin
              if (frame_r) begin
                fstart_r <= now_r; vid_mark_r <= vid_r; aud_mark_r <= aud_r;
              end else begin
                bstart_r <= now_r; ing_mark_r <= ing_sum_r; egr_mark_r <= egr_sum_r;
              end
            end
            state_r <= S_DONE;
          end else if (now_r > start_sel &&
                       (now_r - start_sel) >= 48'(window_r)) begin
            state_r <= S_DIV0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV0: state_r <= S_WAIT0;
        S_WAIT0: if (drsp.done) begin
          q0_r <= drsp.quotient; state_r <= S_DIV1;
        end
        S_DIV1: state_r <= S_WAIT1;
        S_WAIT1: if (drsp.done) begin
          if (query_r) begin
            if (frame_r) begin
              res_r.video_rate <= q0_r[31:0];
              res_r.audio_rate <= drsp.quotient[31:0];
            end else begin
              res_r.ingress_rate <= q0_r;
              res_r.egress_rate  <= drsp.quotient;
            end
          end else if (frame_r) begin
            vid_spd_r <= q0_r[31:0]; aud_spd_r <= drsp.quotient[31:0];
            fstart_r <= now_r; vid_mark_r <= vid_r; aud_mark_r <= aud_r;
          end else begin
            ing_spd_r <= q0_r; egr_spd_r <= drsp.quotient;
            bstart_r <= now_r; ing_mark_r <= ing_sum_r; egr_mark_r <= egr_sum_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (query_r && !ph_r) begin
            ph_r <= 1'b1; frame_r <= 1'b1; state_r <= S_FRAME;
          end else if (query_r) begin
            res_r.ingress_total <= ing_sum_r;
            res_r.egress_total  <= egr_sum_r;
            res_r.drop_total    <= drops_r;
            state_r <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid)
  `ASSERT_CLK(a_no_in_busy, clk, rst_n, drsp.busy |-> !in_ch.ready)
  `ASSERT_CLK(a_div_start, clk, rst_n, dreq.start |-> dreq.divisor != '0)
endmodule

### bench/tb_top.sv
// Testbench for the stream traffic rate meter: directed and random events checked by a predictor
`timescale 1ns / 1ps
module tb_top;
  import strm_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  strm_in_if in_ch (.clk(clk));
  strm_out_if out_ch (.clk(clk));

  stream_traffic_rate_meter u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  typedef struct {
    logic [63:0] ing_sum, egr_sum, ing_mark, egr_mark;
    logic [47:0] byte_start;
    logic [63:0] ing_speed, egr_speed;
    logic [63:0] vid_cnt, aud_cnt, vid_mark, aud_mark;
    logic [47:0] frame_start;
    logic [31:0] vid_speed, aud_speed;
    logic [63:0] drop_cnt;
  } meter_state_t;

  meter_state_t meter;
  logic [15:0] window_ms;
  out_word_t query_q[$];
  logic [47:0] clock_ms;
  int mismatches;
  int idle_cycles;
  bit timed_out;
  bit out_stall_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [63:0] per_second(logic [63:0] delta, logic [63:0] dt);
    logic [63:0] prod;
    prod = delta * 64'd1000;
    return prod / dt;
  endfunction

  function automatic void refresh_bytes(ref meter_state_t m, input logic [47:0] now);
    logic [63:0] dt;
    if (m.byte_start == '0) begin
      m.byte_start = now;
      m.ing_mark = m.ing_sum;
      m.egr_mark = m.egr_sum;
      return;
    end
    if (now <= m.byte_start) return;
    dt = {16'd0, now - m.byte_start};
    if (dt < {48'd0, window_ms}) return;
    m.ing_speed = per_second(m.ing_sum - m.ing_mark, dt);
    m.egr_speed = per_second(m.egr_sum - m.egr_mark, dt);
    m.byte_start = now;
    m.ing_mark = m.ing_sum;
    m.egr_mark = m.egr_sum;
  endfunction

  function automatic void refresh_frames(ref meter_state_t m, input logic [47:0] now);
    logic [63:0] dt;
    logic [63:0] r;
    if (m.frame_start == '0) begin
      m.frame_start = now;
      m.vid_mark = m.vid_cnt;
      m.aud_mark = m.aud_cnt;
      return;
    end
    if (now <= m.frame_start) return;
    dt = {16'd0, now - m.frame_start};
    if (dt < {48'd0, window_ms}) return;
    r = per_second(m.vid_cnt - m.vid_mark, dt);
    m.vid_speed = r[31:0];
    r = per_second(m.aud_cnt - m.aud_mark, dt);
    m.aud_speed = r[31:0];
    m.frame_start = now;
    m.vid_mark = m.vid_cnt;
    m.aud_mark = m.aud_cnt;
  endfunction

  function automatic void clear_meter();
    meter = '{default: '0};
  endfunction

  function automatic void predict_event(in_word_t w);
    meter_state_t snap;
    out_word_t r;
    case (op_t'(w.operation))
      OP_INGRESS, OP_EGRESS: begin
        if (w.byte_count != '0) begin
          if (op_t'(w.operation) == OP_INGRESS) meter.ing_sum += {40'd0, w.byte_count};
          else meter.egr_sum += {40'd0, w.byte_count};
          refresh_bytes(meter, w.now_ms);
        end
      end
      OP_VIDEO: begin
        meter.vid_cnt += 64'd1;
        refresh_frames(meter, w.now_ms);
      end
      OP_AUDIO: begin
        meter.aud_cnt += 64'd1;
        refresh_frames(meter, w.now_ms);
      end
      OP_DROP: meter.drop_cnt += 64'd1;
      OP_QUERY: begin
        snap = meter;
        refresh_bytes(snap, w.now_ms);
        refresh_frames(snap, w.now_ms);
        r.ingress_total = snap.ing_sum;
        r.egress_total = snap.egr_sum;
        r.ingress_rate = snap.ing_speed;
        r.egress_rate = snap.egr_speed;
        r.video_rate = snap.vid_speed;
        r.audio_rate = snap.aud_speed;
        r.drop_total = snap.drop_cnt;
        query_q.push_back(r);
      end
      OP_CLEAR: clear_meter();
      default: ;
    endcase
  endfunction

  function automatic int short_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  task automatic send_word(logic [2:0] op, logic [23:0] cnt, logic [47:0] now, bit gaps);
    in_word_t w;
    int g;
    w.operation = op;
    w.byte_count = cnt;
    w.now_ms = now;
    g = gaps ? short_gap() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_event(w);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (query_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_window(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ms = v;
  endtask

  task automatic test_directed();
    send_word(OP_QUERY, 24'd0, 48'd0, 0);
    send_word(OP_INGRESS, 24'd0, 48'd5, 0);
    send_word(OP_INGRESS, 24'hFFFFFF, 48'd0, 0);
    send_word(OP_INGRESS, 24'hFFFFFF, 48'd10, 0);
    send_word(OP_EGRESS, 24'd1, 48'd10, 0);
    send_word(OP_EGRESS, 24'hABCDEF, 48'd1500, 0);
    send_word(OP_VIDEO, 24'd0, 48'd20, 0);
    send_word(OP_AUDIO, 24'hFFFFFF, 48'd20, 0);
    send_word(OP_VIDEO, 24'd0, 48'd1100, 0);
    send_word(OP_DROP, 24'h5A5A5A, 48'h123456789ABC, 0);
    send_word(OP_QUERY, 24'd0, 48'd1200, 0);
    send_word(OP_QUERY, 24'd0, 48'd5000, 0);
    send_word(OP_NONE, 24'hFFFFFF, 48'hFFFFFFFFFFFF, 0);
    send_word(OP_INGRESS, 24'h800000, 48'hFFFFFFFFFFFF, 0);
    send_word(OP_QUERY, 24'hFFFFFF, 48'hFFFFFFFFFFFF, 0);
    send_word(OP_QUERY, 24'd0, 48'd3, 0);
    send_word(OP_CLEAR, 24'd0, 48'd0, 0);
    send_word(OP_QUERY, 24'd0, 48'd7, 0);
  endtask

  task automatic test_window_extremes();
    write_window(16'd0);
    send_word(OP_INGRESS, 24'd100, 48'd1, 0);
    send_word(OP_VIDEO, 24'd0, 48'd1, 0);
    send_word(OP_INGRESS, 24'd100, 48'd2, 0);
    send_word(OP_VIDEO, 24'd0, 48'd2, 0);
    send_word(OP_QUERY, 24'd0, 48'd3, 0);
    write_window(16'hFFFF);
    send_word(OP_EGRESS, 24'd9, 48'd70000, 0);
    send_word(OP_QUERY, 24'd0, 48'd200000, 0);
    send_word(OP_CLEAR, 24'd0, 48'd0, 0);
  endtask

  task automatic random_burst(int n);
    int k;
    int r;
    logic [2:0] op;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_INGRESS;
      else if (r < 45) op = OP_EGRESS;
      else if (r < 58) op = OP_VIDEO;
      else if (r < 70) op = OP_AUDIO;
      else if (r < 76) op = OP_DROP;
      else if (r < 96) op = OP_QUERY;
      else if (r < 98) op = OP_CLEAR;
      else op = OP_NONE;
      if ($urandom_range(0, 9) != 0) clock_ms = clock_ms + 48'($urandom_range(0, 400));
      else if ($urandom_range(0, 3) == 0) clock_ms = 48'({$urandom, $urandom});
      send_word(op, $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(0, 5000)),
                clock_ms, 1);
      if (k == n / 2) drain();
    end
  endtask

  task automatic test_random();
    clock_ms = 48'd1;
    write_window(16'd1);
    random_burst(300);
    write_window(16'd250);
    random_burst(350);
    write_window(16'($urandom_range(1, 2000)));
    random_burst(350);
    write_window(16'd1000);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall_on <= 1'b0;
    end else begin
      if ($urandom_range(0, 7) == 0) out_stall_on <= !out_stall_on;
      out_ch.ready <= out_stall_on ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 4) != 0);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    out_word_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (query_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", a);
      end else begin
        e = query_q.pop_front();
        if (a !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", e, a);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000 && !timed_out) begin
      timed_out = 1'b1;
      $display("stream_traffic_rate_meter regression: fail");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    window_ms = WindowReset;
    clear_meter();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_extremes();
    test_random();
    drain();
    if (mismatches == 0 && query_q.size() == 0)
      $display("stream_traffic_rate_meter regression: pass");
    else
      $display("stream_traffic_rate_meter regression: fail");
    $finish;
  end
endmodule

### stream_traffic_rate_meter.f
+incdir+design
design/strm_pkg.sv
design/strm_if.sv
design/strm_div.sv
design/stream_traffic_rate_meter.sv
bench/tb_top.sv
